FILE: design/erd_pkg.sv
package erd_pkg;

  localparam int MaxNameBytes = 8;
  localparam int NameChars    = 7;
  localparam int TableEntries = 128;
  localparam int ListLen      = 113;
  localparam int MaxResults   = 10;
  localparam int CntW         = $clog2(MaxNameBytes + 1);
  localparam int BufIdxW      = $clog2(MaxNameBytes);
  localparam int RpDepth      = MaxNameBytes + 1;
  localparam int TabIdxW      = $clog2(TableEntries);
  localparam int QDepth       = 16;
  localparam int QIdxW        = $clog2(QDepth);

  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChHash = 8'h23;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_run_end;
    logic       out_stream_end;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FEED,
    ST_LOOK,
    ST_MATCH,
    ST_FLUSH,
    ST_DRAIN
  } state_t;

  // name packed first character in the top byte, zero padded, then code
  typedef logic [8*NameChars+7:0] ent_t;

  function automatic ent_t ent(input string s, input logic [7:0] c);
    ent_t e;
    int   i;
    e = '0;
    for (i = 0; i < s.len(); i++) begin
      e[8*NameChars+7-8*i -: 8] = s[i];
    end
    e[7:0] = c;
    return e;
  endfunction

  function automatic ent_t ent_rom(input logic [TabIdxW-1:0] a);
    ent_t e;
    e = '0;
    case (a)
      0: e = ent("Aacute", 8'hC1);   1: e = ent("Agrave", 8'hC0);
      2: e = ent("Acirc", 8'hC2);    3: e = ent("Atilde", 8'hC3);
      4: e = ent("Auml", 8'hC4);     5: e = ent("Aring", 8'hC5);
      6: e = ent("AElig", 8'hC6);    7: e = ent("Ccedil", 8'hC7);
      8: e = ent("Eacute", 8'hC9);   9: e = ent("Egrave", 8'hC8);
      10: e = ent("Ecirc", 8'hCA);   11: e = ent("Euml", 8'hCB);
      12: e = ent("Iacute", 8'hCD);  13: e = ent("Igrave", 8'hCC);
      14: e = ent("Icirc", 8'hCE);   15: e = ent("Iuml", 8'hCF);
      16: e = ent("ETH", 8'hD0);     17: e = ent("Ntilde", 8'hD1);
      18: e = ent("Oacute", 8'hD3);  19: e = ent("Ograve", 8'hD2);
      20: e = ent("Ocirc", 8'hD4);   21: e = ent("Otilde", 8'hD5);
      22: e = ent("Ouml", 8'hD6);    23: e = ent("Oslash", 8'hD8);
      24: e = ent("Uacute", 8'hDA);  25: e = ent("Ugrave", 8'hD9);
      26: e = ent("Ucirc", 8'hDB);   27: e = ent("Uuml", 8'hDC);
      28: e = ent("Yacute", 8'hDD);  29: e = ent("THORN", 8'hDE);
      30: e = ent("aacute", 8'hE1);  31: e = ent("agrave", 8'hE0);
      32: e = ent("acirc", 8'hE2);   33: e = ent("atilde", 8'hE3);
      34: e = ent("auml", 8'hE4);    35: e = ent("aring", 8'hE5);
      36: e = ent("aelig", 8'hE6);   37: e = ent("ccedil", 8'hE7);
      38: e = ent("eacute", 8'hE9);  39: e = ent("egrave", 8'hE8);
      40: e = ent("ecirc", 8'hEA);   41: e = ent("euml", 8'hEB);
      42: e = ent("iacute", 8'hED);  43: e = ent("igrave", 8'hEC);
      44: e = ent("icirc", 8'hEE);   45: e = ent("iuml", 8'hEF);
      46: e = ent("eth", 8'hF0);     47: e = ent("ntilde", 8'hF1);
      48: e = ent("oacute", 8'hF3);  49: e = ent("ograve", 8'hF2);
      50: e = ent("ocirc", 8'hF4);   51: e = ent("otilde", 8'hF5);
      52: e = ent("ouml", 8'hF6);    53: e = ent("oslash", 8'hF8);
      54: e = ent("szlig", 8'hDF);   55: e = ent("uacute", 8'hFA);
      56: e = ent("ugrave", 8'hF9);  57: e = ent("ucirc", 8'hFB);
      58: e = ent("uuml", 8'hFC);    59: e = ent("yacute", 8'hFD);
      60: e = ent("thorn", 8'hFE);   61: e = ent("yuml", 8'hFF);
      62: e = ent("iexcl", 8'hA1);   63: e = ent("cent", 8'hA2);
      64: e = ent("pound", 8'hA3);   65: e = ent("curren", 8'hA4);
      66: e = ent("yen", 8'hA5);     67: e = ent("brvbar", 8'hA6);
      68: e = ent("sect", 8'hA7);    69: e = ent("uml", 8'hA8);
      70: e = ent("ordf", 8'hAA);    71: e = ent("laquo", 8'hAB);
      72: e = ent("not", 8'hAC);     73: e = ent("shy", 8'hAD);
      74: e = ent("macr", 8'hAF);    75: e = ent("deg", 8'hB0);
      76: e = ent("plusmn", 8'hB1);  77: e = ent("sup2", 8'hB2);
      78: e = ent("sup3", 8'hB3);    79: e = ent("acute", 8'hB4);
      80: e = ent("micro", 8'hB5);   81: e = ent("para", 8'hB6);
      82: e = ent("middot", 8'hB7);  83: e = ent("cedil", 8'hB8);
      84: e = ent("sup1", 8'hB9);    85: e = ent("ordm", 8'hBA);
      86: e = ent("raquo", 8'hBB);   87: e = ent("frac14", 8'hBC);
      88: e = ent("frac12", 8'hBD);  89: e = ent("frac34", 8'hBE);
      90: e = ent("iquest", 8'hBF);  91: e = ent("times", 8'hD7);
      92: e = ent("divide", 8'hF7);  93: e = ent("amp", 8'h26);
      94: e = ent("gt", 8'h3E);      95: e = ent("lt", 8'h3C);
      96: e = ent("copy", 8'hA9);    97: e = ent("reg", 8'hAE);
      98: e = ent("trade", 8'h99);   99: e = ent("slash", 8'h5C);
      100: e = ent("obrace", 8'h7B); 101: e = ent("cbrace", 8'h7D);
      102: e = ent("quot", 8'h22);   103: e = ent("ldquo", 8'h22);
      104: e = ent("rdquo", 8'h22);  105: e = ent("lsquo", 8'h27);
      106: e = ent("rsquo", 8'h27);  107: e = ent("#8216", 8'h27);
      108: e = ent("#8217", 8'h27);  109: e = ent("#8220", 8'h22);
      110: e = ent("#8221", 8'h22);  111: e = ent("#8212", 8'h97);
      112: e = ent("#8211", 8'h96);
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

FILE: design/entity_reference_decoder.sv
// channel | dir | payload    | handshake
// in_     | in  | in_word_t  | in_valid / in_ready
// out_    | out | out_word_t | out_valid / out_ready
// a plain byte passes accept, feed, a feed step that finds nothing left to feed, and a drain
// step that closes the run, before the next word is accepted.
// a closing byte adds a look and a flush step; a non-numeric name also walks the 113 used rom
// entries one entry a cycle, and a miss refeeds the name one byte a cycle.
// reset (synchronous, rst_n low) clears the reference state and the output queue.
// results wait in a 16-deep queue; a word is taken only while ten slots are free.
module entity_reference_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  erd_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output erd_pkg::out_word_t  out_data
);
  import erd_pkg::*;

  state_t state_r, state_nxt;

  logic [7:0]          buf_r [MaxNameBytes];
  logic [CntW-1:0]     cnt_r;
  logic                inref_r;
  logic                last_r;
  // bytes still to be fed: the input word, then any replayed names
  logic [7:0]          rp_r [RpDepth];
  logic [CntW-1:0]     rp_len_r, rp_pos_r;
  logic [7:0]          rp_nxt [RpDepth];
  logic [CntW-1:0]     rp_len_nxt;
  logic [7:0]          cur;
  logic                have_cur;
  logic [TabIdxW-1:0]  tidx_r;
  logic                hit_r;
  logic [7:0]          hit_code_r;
  logic [7:0]          term_r;
  logic                has_term_r;
  ent_t                tdata;
  // last result so far, held until it is known whether it closes the run
  logic [7:0]          hold_r;
  logic                hold_v_r;

  // output queue
  out_word_t           q_mem [QDepth];
  logic [QIdxW:0]      q_wp_r, q_rp_r;
  logic [QIdxW:0]      q_used;
  logic                q_room;
  logic                q_push;
  out_word_t           q_push_word;
  logic                emit;
  logic [7:0]          emit_byte;

  assign q_used = q_wp_r - q_rp_r;
  assign q_room = q_used <= (QIdxW+1)'(QDepth - MaxResults);

  erd_table u_table (.clk(clk), .addr(tidx_r), .rdata(tdata));

  assign in_ready = (state_r == ST_IDLE) && q_room;

  assign have_cur = rp_pos_r < rp_len_r;
  assign cur      = have_cur ? rp_r[rp_pos_r] : 8'h00;

  // numeric name value, at most seven digits, stops once it reaches 256
  logic [7:0] num_v;
  logic       num_ok;
  always_comb begin
    logic [12:0] v;
    logic        stop;
    v = '0;
    stop = 1'b0;
    for (int i = 1; i < MaxNameBytes; i++) begin
      if (!stop && i < cnt_r && buf_r[i] >= 8'h30 && buf_r[i] <= 8'h39 && v < 13'd256)
        v = 13'(v * 10 + (buf_r[i] - 8'h30));
      else
        stop = 1'b1;
    end
    num_ok = (cnt_r != '0) && (buf_r[0] == ChHash) && (v < 13'd256);
    num_v = v[7:0];
  end

  // name compare against the registered rom word; a nul byte never matches
  logic name_eq;
  always_comb begin
    name_eq = (cnt_r != '0) && (cnt_r <= CntW'(NameChars));
    for (int k = 0; k < NameChars; k++) begin
      if (k < cnt_r) begin
        if (tdata[8*NameChars+7-8*k -: 8] != buf_r[k] || buf_r[k] == 8'h00) name_eq = 1'b0;
      end else if (tdata[8*NameChars+7-8*k -: 8] != 8'h00) begin
        name_eq = 1'b0;
      end
    end
  end

  // replay list after a miss: the name, the terminator if there was one, then what was still pending
  always_comb begin
    int src;
    rp_len_nxt = cnt_r + {{(CntW-1){1'b0}}, has_term_r} + (rp_len_r - rp_pos_r);
    for (int k = 0; k < RpDepth; k++) begin
      src = int'(rp_pos_r) + k - int'(cnt_r) - int'(has_term_r);
      if (k < int'(cnt_r))
        rp_nxt[k] = buf_r[BufIdxW'(k)];
      else if (has_term_r && k == int'(cnt_r))
        rp_nxt[k] = term_r;
      else if (src >= 0 && src < int'(rp_len_r))
        rp_nxt[k] = rp_r[CntW'(src)];
      else
        rp_nxt[k] = 8'h00;
    end
  end

  logic resolve_now;
  logic tab_done;
  assign resolve_now = inref_r && (cur == ChSemi || cnt_r >= CntW'(MaxNameBytes));
  // rom data is registered: it appears the cycle after its address
  assign tab_done = (tidx_r == TabIdxW'(ListLen));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid && in_ready) state_nxt = ST_FEED;
      ST_FEED: begin
        if (have_cur) begin
          if (resolve_now) state_nxt = ST_LOOK;
        end else if (last_r && inref_r) begin
          state_nxt = ST_LOOK;
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_LOOK:  state_nxt = num_ok ? ST_FLUSH : ST_MATCH;
      ST_MATCH: if (name_eq || tab_done) state_nxt = ST_FLUSH;
      ST_FLUSH: state_nxt = ST_FEED;
      ST_DRAIN: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    emit = 1'b0;
    emit_byte = cur;
    unique case (state_r)
      ST_FEED: emit = have_cur && !inref_r && cur != ChAmp;
      ST_FLUSH: begin
        emit = 1'b1;
        emit_byte = num_ok ? num_v : (hit_r ? hit_code_r : ChAmp);
      end
      default: ;
    endcase
    q_push = 1'b0;
    q_push_word = '{out_byte: hold_r, out_run_end: 1'b0, out_stream_end: 1'b0};
    if (emit && hold_v_r) begin
      q_push = 1'b1;
    end else if (state_r == ST_DRAIN && hold_v_r) begin
      q_push = 1'b1;
      q_push_word.out_run_end = 1'b1;
      q_push_word.out_stream_end = last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      inref_r <= 1'b0;
      cnt_r <= '0;
      last_r <= 1'b0;
      rp_len_r <= '0;
      rp_pos_r <= '0;
      hold_v_r <= 1'b0;
      q_wp_r <= '0;
      q_rp_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid && out_ready) q_rp_r <= q_rp_r + 1'b1;
      if (q_push) q_wp_r <= q_wp_r + 1'b1;
      if (emit) begin
        hold_r <= emit_byte;
        hold_v_r <= 1'b1;
      end else if (state_r == ST_DRAIN) begin
        hold_v_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: if (in_valid && in_ready) begin
          rp_r[0] <= in_data.in_byte;
          rp_len_r <= CntW'(1);
          rp_pos_r <= '0;
          last_r <= in_data.in_last;
        end
        ST_FEED: begin
          tidx_r <= '0;
          hit_r <= 1'b0;
          if (have_cur) begin
            rp_pos_r <= rp_pos_r + 1'b1;
            if (!inref_r) begin
              if (cur == ChAmp) begin
                inref_r <= 1'b1;
                cnt_r <= '0;
              end
            end else if (resolve_now) begin
              term_r <= cur;
              has_term_r <= 1'b1;
            end else begin
              buf_r[cnt_r[BufIdxW-1:0]] <= cur;
              cnt_r <= cnt_r + 1'b1;
            end
          end else begin
            // end of stream: an open name resolves without a terminator
            has_term_r <= 1'b0;
          end
        end
        ST_LOOK: tidx_r <= tidx_r + 1'b1;
        ST_MATCH: begin
          if (name_eq) begin
            hit_r <= 1'b1;
            hit_code_r <= tdata[7:0];
          end else if (!tab_done) begin
            tidx_r <= tidx_r + 1'b1;
          end
        end
        ST_FLUSH: begin
          inref_r <= 1'b0;
          cnt_r <= '0;
          if (!num_ok && !hit_r) begin
            for (int i = 0; i < RpDepth; i++) rp_r[i] <= rp_nxt[i];
            rp_len_r <= rp_len_nxt;
            rp_pos_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) q_mem[q_wp_r[QIdxW-1:0]] <= q_push_word;
  end

  assign out_valid = (q_wp_r != q_rp_r);
  assign out_data  = q_mem[q_rp_r[QIdxW-1:0]];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_used <= (QIdxW+1)'(QDepth)) else $error("output queue overflow");
  a_in_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_IDLE) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while waiting");
  a_drain_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |=> state_r == ST_IDLE) else $error("drain did not return");

endmodule

FILE: design/erd_table.sv
// entity name table: synchronous rom, one entry read per cycle
module erd_table (
  input  logic                         clk,
  input  logic [erd_pkg::TabIdxW-1:0]  addr,
  output erd_pkg::ent_t                rdata
);
  import erd_pkg::*;

  ent_t mem [TableEntries];

  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      mem[i] = ent_rom(TabIdxW'(i));
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end

endmodule
